FILE: sv/assert_macros.svh
// assertion macros shared by the cache rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold on every clock edge outside reset
`define ASSERT_ALWAYS(label, prop, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: label");

// antecedent implies consequent in the following cycle
`define ASSERT_NEXT(label, ante, cons, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

FILE: sv/lkvc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the lru key-value cache
// no dependencies
package lkvc_pkg;
  localparam int unsigned Entries   = 128;
  localparam int unsigned IdxBits   = $clog2(Entries);
  localparam int unsigned CntBits   = $clog2(Entries + 1);
  localparam int unsigned KeyBits   = 64;
  localparam int unsigned ValBits   = 64;
  localparam int unsigned TimeBits  = 32;
  localparam int unsigned HitBits   = 32;
  localparam int unsigned LifeBits  = 16;
  localparam int unsigned SlotOutBits = 7;
  localparam int unsigned OccOutBits  = 8;

  typedef logic [IdxBits-1:0] idx_t;

  // one slot as it travels along the ring of cells
  typedef struct packed {
    logic                valid;
    logic [KeyBits-1:0]  key;
    logic [ValBits-1:0]  value;
    logic [HitBits-1:0]  hits;
    logic [LifeBits-1:0] life;
    logic [TimeBits-1:0] stamp;
    idx_t                idx;
  } slot_t;

  // control from the sequencer to every cell
  typedef struct packed {
    logic                rotate;
    logic                upd_hit;
    logic                wr_new;
    logic                is_set;
    idx_t                target;
    logic [KeyBits-1:0]  key;
    logic [ValBits-1:0]  value;
    logic [LifeBits-1:0] life;
    logic [TimeBits-1:0] stamp;
  } cell_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SCAN   = 4'b0010,
    ST_APPLY  = 4'b0100,
    ST_ALIGN  = 4'b1000
  } state_e;
endpackage

FILE: sv/lkvc_cell.sv
`timescale 1ns / 1ps
// one slot cell of the rotating table
// depends on lkvc_pkg
module lkvc_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lkvc_pkg::cell_ctl_t ctl_i,
  input  lkvc_pkg::slot_t    prev_i,
  input  lkvc_pkg::idx_t     home_i,
  output lkvc_pkg::slot_t    slot_o
);
  lkvc_pkg::slot_t cur_slot, slot_d;
  logic valid_q;
  lkvc_pkg::idx_t idx_q;
  logic [lkvc_pkg::KeyBits-1:0]  key_q;
  logic [lkvc_pkg::ValBits-1:0]  value_q;
  logic [lkvc_pkg::HitBits-1:0]  hits_q;
  logic [lkvc_pkg::LifeBits-1:0] life_q;
  logic [lkvc_pkg::TimeBits-1:0] stamp_q;

  always_comb begin
    cur_slot.valid = valid_q;
    cur_slot.key   = key_q;
    cur_slot.value = value_q;
    cur_slot.hits  = hits_q;
    cur_slot.life  = life_q;
    cur_slot.stamp = stamp_q;
    cur_slot.idx   = idx_q;
  end

  always_comb begin
    slot_d = cur_slot;
    if (ctl_i.rotate) begin
      slot_d = prev_i;
    end else if (cur_slot.idx == ctl_i.target) begin
      if (ctl_i.upd_hit) begin
        slot_d.stamp = ctl_i.stamp;
        if (ctl_i.is_set) begin
          slot_d.value = ctl_i.value;
        end else if (cur_slot.hits != '1) begin
          slot_d.hits = cur_slot.hits + 1'b1;
        end
      end else if (ctl_i.wr_new) begin
        slot_d.valid = 1'b1;
        slot_d.key   = ctl_i.key;
        slot_d.value = ctl_i.value;
        slot_d.hits  = '0;
        slot_d.life  = ctl_i.life;
        slot_d.stamp = ctl_i.stamp;
      end
    end
  end

  // payload without reset, valid and index with reset
  always_ff @(posedge clk_i) begin
    key_q   <= slot_d.key;
    value_q <= slot_d.value;
    hits_q  <= slot_d.hits;
    life_q  <= slot_d.life;
    stamp_q <= slot_d.stamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= home_i;
    end else begin
      valid_q <= slot_d.valid;
      idx_q   <= slot_d.idx;
    end
  end

  assign slot_o = cur_slot;
endmodule

FILE: sv/lru_key_value_cache_top.sv
`timescale 1ns / 1ps
// lru key-value cache: a ring of 128 slot cells rotated past one compare port
// after the accepting edge the sequencer walks scan, apply and align; done_o is high in align
// the ring makes one full turn to search key, free slot and oldest stamp and is
// then back home; the apply state writes the update, the align state presents the result
// one request at a time, a new one is taken only once busy has fallen
// reset (async, active low) empties the table; the receiver cannot stall
`include "assert_macros.svh"
module lru_key_value_cache_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        mode_i,
  input  logic [63:0] lookup_key_i,
  input  logic [63:0] data_value_i,
  input  logic [15:0] lifetime_i,
  input  logic [31:0] now_time_i,
  output logic        done_o,
  output logic        found_o,
  output logic [63:0] read_value_o,
  output logic [6:0]  slot_index_o,
  output logic        replaced_o,
  output logic [7:0]  occupied_count_o
);
  localparam int unsigned N = lkvc_pkg::Entries;
  localparam int unsigned IB = lkvc_pkg::IdxBits;

  lkvc_pkg::state_e state_q, state_d;
  lkvc_pkg::slot_t ring [N];
  lkvc_pkg::cell_ctl_t ctl;
  logic [IB:0] cnt_q, cnt_d;
  logic is_set_q;
  logic [lkvc_pkg::KeyBits-1:0] key_q;
  logic [lkvc_pkg::ValBits-1:0] val_q;
  logic [lkvc_pkg::LifeBits-1:0] life_q;
  logic [lkvc_pkg::TimeBits-1:0] now_q;
  logic hit_q, free_q, hit_d, free_d;
  lkvc_pkg::idx_t hit_idx_q, free_idx_q, old_idx_q, hit_idx_d, free_idx_d, old_idx_d;
  logic [lkvc_pkg::TimeBits-1:0] old_t_q, old_t_d;
  logic [lkvc_pkg::CntBits-1:0] fill_q;
  logic [lkvc_pkg::ValBits-1:0] rv_q, rv_d;
  lkvc_pkg::slot_t head;

  genvar g;
  for (g = 0; g < N; g++) begin : g_cell
    lkvc_cell u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .ctl_i (ctl),
      .prev_i(ring[(g + N - 1) % N]),
      .home_i(IB'(g)),
      .slot_o(ring[g])
    );
  end

  // the last cell is the compare port; ring moves up one cell per cycle while scanning
  assign head = ring[N-1];

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    hit_d = hit_q; hit_idx_d = hit_idx_q;
    free_d = free_q; free_idx_d = free_idx_q;
    old_t_d = old_t_q; old_idx_d = old_idx_q;
    rv_d = rv_q;
    ctl = '0;
    ctl.is_set = is_set_q;
    ctl.key = key_q; ctl.value = val_q; ctl.life = life_q; ctl.stamp = now_q;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: begin
        if (start) begin
          state_d = lkvc_pkg::ST_SCAN;
          cnt_d = '0;
          hit_d = 1'b0; free_d = 1'b0;
          old_t_d = '1; old_idx_d = '0;
        end
      end
      lkvc_pkg::ST_SCAN: begin
        ctl.rotate = 1'b1;
        // inspect the slot leaving the last cell
        if (head.valid && head.key == key_q && !hit_q) begin
          hit_d = 1'b1; hit_idx_d = head.idx; rv_d = head.value;
        end
        if (!head.valid && (!free_q || head.idx < free_idx_q)) begin
          free_d = 1'b1; free_idx_d = head.idx;
        end
        if (head.valid && (head.stamp < old_t_q ||
            (head.stamp == old_t_q && head.idx < old_idx_q) || cnt_q == '0)) begin
          old_t_d = head.stamp; old_idx_d = head.idx;
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == (IB+1)'(N - 1)) state_d = lkvc_pkg::ST_APPLY;
      end
      lkvc_pkg::ST_APPLY: begin
        state_d = lkvc_pkg::ST_ALIGN;
        cnt_d = '0;
        if (hit_q) begin
          ctl.upd_hit = 1'b1; ctl.target = hit_idx_q;
        end else if (is_set_q) begin
          ctl.wr_new = 1'b1;
          ctl.target = free_q ? free_idx_q : old_idx_q;
        end
      end
      lkvc_pkg::ST_ALIGN: begin
        state_d = lkvc_pkg::ST_IDLE;
      end
      default: state_d = lkvc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      is_set_q <= mode_i;
      key_q <= lookup_key_i; val_q <= data_value_i;
      life_q <= lifetime_i; now_q <= now_time_i;
    end
    hit_idx_q <= hit_idx_d; free_idx_q <= free_idx_d;
    old_t_q <= old_t_d; old_idx_q <= old_idx_d; rv_q <= rv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkvc_pkg::ST_IDLE;
      cnt_q <= '0; hit_q <= 1'b0; free_q <= 1'b0; fill_q <= '0;
      done_o <= 1'b0;
    end else begin
      state_q <= state_d; cnt_q <= cnt_d; hit_q <= hit_d; free_q <= free_d;
      done_o <= (state_q == lkvc_pkg::ST_APPLY);
      if (state_q == lkvc_pkg::ST_APPLY && !hit_q && is_set_q && free_q)
        fill_q <= fill_q + 1'b1;
    end
  end

  // the ring is back home after a full turn, so outputs come from registers
  always_ff @(posedge clk_i) begin
    if (state_q == lkvc_pkg::ST_APPLY) begin
      found_o <= hit_q;
      read_value_o <= (hit_q && !is_set_q) ? rv_q : '0;
      replaced_o <= !hit_q && is_set_q && !free_q;
      slot_index_o <= hit_q ? lkvc_pkg::SlotOutBits'(hit_idx_q) :
                      !is_set_q ? '0 :
                      free_q ? lkvc_pkg::SlotOutBits'(free_idx_q) :
                      lkvc_pkg::SlotOutBits'(old_idx_q);
      occupied_count_o <= lkvc_pkg::OccOutBits'(fill_q +
          lkvc_pkg::CntBits'(!hit_q && is_set_q && free_q));
    end
  end

  assign busy = (state_q != lkvc_pkg::ST_IDLE);

  `ASSERT_ALWAYS(a_fill_range, fill_q <= lkvc_pkg::CntBits'(N), clk_i, rst_ni)
  `ASSERT_NEXT(a_done_after_apply, state_q == lkvc_pkg::ST_APPLY, done_o, clk_i, rst_ni)
  `ASSERT_ALWAYS(a_done_idle, !done_o || state_q == lkvc_pkg::ST_ALIGN, clk_i, rst_ni)
endmodule
